/* rtl/core/lpr_pkg.sv */
// Shared types, codes and helper function of the longest prefix router.
`default_nettype none
package lpr_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 4;
    localparam int TTL_W  = 8;
    localparam int STAT_W = 3;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_ROUTE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FORWARDED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROP_TTL  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NO_ROUTE  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

    localparam logic [TTL_W-1:0] TTL_MIN_FWD = 8'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] hop;
        logic              gateway;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic len_eq;
        logic len_gt;
    } t_cmp;

    // Leading-ones mask; a length of 32 or more gives all ones.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lpr_req_if.sv */
// Request channel of the longest prefix router: valid, ready and the request fields.
`default_nettype none
interface lpr_req_if;
    import lpr_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic [ADDR_W-1:0] hop_address;
    logic              has_hop;
    logic [PORT_W-1:0] port_in;
    logic [TTL_W-1:0]  ttl_in;

    modport source (
        output valid, func, address, prefix_len, hop_address, has_hop, port_in, ttl_in,
        input  ready
    );
    modport sink (
        input  valid, func, address, prefix_len, hop_address, has_hop, port_in, ttl_in,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/core/lpr_rsp_if.sv */
// Response channel of the longest prefix router: valid, ready and the result fields.
`default_nettype none
interface lpr_rsp_if;
    import lpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] out_hop;
    logic [TTL_W-1:0]  out_ttl;

    modport source (
        output valid, status, out_port, out_hop, out_ttl,
        input  ready
    );
    modport sink (
        input  valid, status, out_port, out_hop, out_ttl,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/core/lpr_table.sv */
// Route table memory: one write port and one registered read port.
`default_nettype none
module lpr_table #(
    parameter int ROUTES = 64,
    parameter int IW     = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IW-1:0]    i_waddr,
    input  wire lpr_pkg::t_entry  i_wdata,
    input  wire logic [IW-1:0]    i_raddr,
    output lpr_pkg::t_entry       o_rdata
);
    import lpr_pkg::*;

    t_entry r_mem [ROUTES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/core/lpr_match.sv */
// Shared compare unit: masked prefix match and length comparisons for one entry.
`default_nettype none
module lpr_match (
    input  wire logic [lpr_pkg::ADDR_W-1:0] i_key,
    input  wire logic [lpr_pkg::LEN_W-1:0]  i_key_len,
    input  wire logic [lpr_pkg::LEN_W-1:0]  i_best_len,
    input  wire lpr_pkg::t_entry            i_entry,
    output lpr_pkg::t_cmp                   o_cmp
);
    import lpr_pkg::*;

    assign o_cmp.hit    = ((i_key & len_mask(i_entry.length)) == i_entry.prefix);
    assign o_cmp.len_eq = (i_entry.length == i_key_len);
    assign o_cmp.len_gt = (i_entry.length > i_best_len);
endmodule
`default_nettype wire

/* rtl/core/ipv4_longest_prefix_router.sv */
// Top level of the IPv4 longest prefix match router with its scan sequencer.
//
// Usage: requests arrive on i_req (valid/ready). A request with func clear
// inserts a route (prefix, length, optional next hop, port); one with func set
// routes a datagram to its destination address. Every request produces exactly
// one result on o_rsp (valid/ready) carrying a status and, for a forwarded
// datagram, the port, next hop and decremented TTL.
// A request walks the filled part of the table one entry per cycle through a
// single compare unit fed by the table memory's read port. A datagram whose
// TTL is at most one skips the scan and goes straight to the done state.
// The block holds one request at a time: i_req.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so a new
// request is accepted while that result waits; if the receiver is still
// stalling when the next result is ready, the sequencer holds it until the
// output register frees.
// Reset (synchronous, active low) empties the table at once by clearing the
// fill count; entries are filled in order, so no clearing pass is needed.
`default_nettype none
module ipv4_longest_prefix_router #(
    parameter int ROUTES = 64,
    parameter int PORTS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lpr_req_if.sink   i_req,
    lpr_rsp_if.source o_rsp
);
    import lpr_pkg::*;

    localparam int CW = $clog2(ROUTES + 1);
    localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam logic [CW-1:0]     ROUTES_C = CW'(ROUTES);
    localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(PORTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;

    // Latched request. For an insert the address is already masked to its length.
    logic              r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_hop;
    logic              r_gw;
    logic [PORT_W-1:0] r_port;
    logic [TTL_W-1:0]  r_ttl;

    // Scan state: r_idx is the next read address, r_pidx the entry now on the read data.
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [IW-1:0]     r_pidx;
    logic              r_found;
    logic [LEN_W-1:0]  r_best_len;
    t_entry            r_best;
    logic [IW-1:0]     r_slot;

    // Result being built, then the output register.
    logic [STAT_W-1:0] r_status;
    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [PORT_W-1:0] r_out_port;
    logic [ADDR_W-1:0] r_out_hop;
    logic [TTL_W-1:0]  r_out_ttl;

    logic              accept;
    logic              issue;
    logic              scan_end;
    logic              ins_hit;
    logic              best_upd;
    logic              out_free;
    logic [LEN_W-1:0]  in_len;
    t_entry            rd_entry;
    t_entry            wr_entry;
    t_cmp              cmp;

    assign i_req.ready = (r_state == S_IDLE) & i_rst_n;
    assign accept      = i_req.valid & i_req.ready;

    assign in_len = (i_req.prefix_len > MAX_LEN) ? MAX_LEN : i_req.prefix_len;

    // One read per cycle over the filled slots; the result of a read is compared in the following cycle.
    assign issue    = (r_state == S_SCAN) && (r_idx != r_count);
    assign scan_end = (r_state == S_SCAN) && (r_idx == r_count) && !r_pend;

    assign ins_hit  = (r_state == S_SCAN) && r_pend && (r_func == FUNC_INSERT)
                      && cmp.hit && cmp.len_eq;
    assign best_upd = (r_state == S_SCAN) && r_pend && (r_func == FUNC_ROUTE)
                      && cmp.hit && (!r_found || cmp.len_gt);

    assign out_free = !r_out_vld || o_rsp.ready;

    assign wr_entry.prefix  = r_addr;
    assign wr_entry.length  = r_len;
    assign wr_entry.hop     = r_gw ? r_hop : '0;
    assign wr_entry.gateway = r_gw;
    assign wr_entry.port    = r_port;

    lpr_table #(
        .ROUTES (ROUTES),
        .IW     (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_entry)
    );

    lpr_match u_match (
        .i_key      (r_addr),
        .i_key_len  (r_len),
        .i_best_len (r_best_len),
        .i_entry    (rd_entry),
        .o_cmp      (cmp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_req.func == FUNC_ROUTE) && (i_req.ttl_in < TTL_MIN_FWD)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ins_hit) begin
                    n_state = S_WRITE;
                end else if (scan_end) begin
                    if ((r_func == FUNC_INSERT) && (r_count != ROUTES_C)) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (scan_end && (r_func == FUNC_INSERT) && (r_count != ROUTES_C)) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request, scan and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= i_req.func;
            r_len      <= in_len;
            r_hop      <= i_req.hop_address;
            r_gw       <= i_req.has_hop;
            r_ttl      <= i_req.ttl_in;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_best_len <= '0;
            r_status   <= STAT_DROP_TTL;
            if (i_req.func == FUNC_INSERT) begin
                r_addr <= i_req.address & len_mask(in_len);
            end else begin
                r_addr <= i_req.address;
            end
            if (int'(i_req.port_in) >= PORTS) begin
                r_port <= PORT_MAX;
            end else begin
                r_port <= i_req.port_in;
            end
        end
        if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        r_pidx <= r_idx[IW-1:0];
        if (best_upd) begin
            r_found    <= 1'b1;
            r_best_len <= rd_entry.length;
            r_best     <= rd_entry;
        end
        if (ins_hit) begin
            r_slot <= r_pidx;
        end else if (scan_end) begin
            r_slot <= r_count[IW-1:0];
            if (r_func == FUNC_INSERT) begin
                r_status <= STAT_FULL;
            end else if (r_found) begin
                r_status <= STAT_FORWARDED;
            end else begin
                r_status <= STAT_NO_ROUTE;
            end
        end
        if (r_state == S_WRITE) begin
            r_status <= STAT_INSERTED;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_status;
            if (r_status == STAT_FORWARDED) begin
                r_out_port <= r_best.port;
                r_out_hop  <= r_best.gateway ? r_best.hop : r_addr;
                r_out_ttl  <= r_ttl - 1'b1;
            end else begin
                r_out_port <= '0;
                r_out_hop  <= '0;
                r_out_ttl  <= '0;
            end
        end
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.out_port = r_out_port;
    assign o_rsp.out_hop  = r_out_hop;
    assign o_rsp.out_ttl  = r_out_ttl;
endmodule
`default_nettype wire

/* rtl/core/lpr_checker.sv */
// Port-level checks of the longest prefix router and their binding to the top level.
`default_nettype none
module lpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [2:0] i_rsp_status,
    input wire logic [3:0] i_rsp_port,
    input wire logic [31:0] i_rsp_hop,
    input wire logic [7:0] i_rsp_ttl
);
    import lpr_pkg::*;

    // A pending result stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result withdrawn before it was taken");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in progress");

    // A forwarded datagram always leaves with a live TTL.
    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == STAT_FORWARDED) |-> (i_rsp_ttl != '0))
        else $error("forwarded datagram with zero TTL");

    // Only a forwarded datagram carries port, next hop and TTL.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != STAT_FORWARDED)
        |-> (i_rsp_port == '0) && (i_rsp_hop == '0) && (i_rsp_ttl == '0))
        else $error("non-forwarded result carries routing fields");
endmodule

bind ipv4_longest_prefix_router lpr_checker u_lpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_port   (o_rsp.out_port),
    .i_rsp_hop    (o_rsp.out_hop),
    .i_rsp_ttl    (o_rsp.out_ttl)
);
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the IPv4 longest prefix match router.
`timescale 1ns / 100ps
module tb;
    import lpr_pkg::*;

    localparam int N_ROUTES = 64;
    localparam int N_PORTS  = 16;
    localparam int N_RANDOM = 1180;
    // This covers the longest scan of any request still in flight.
    localparam int DRAIN_CYCLES = 80;

    // One request as it is offered on the request channel.
    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [ADDR_W-1:0] hop_address;
        logic              has_hop;
        logic [PORT_W-1:0] port_in;
        logic [TTL_W-1:0]  ttl_in;
    } t_route_req;

    // One result as the router should return it.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] out_hop;
        logic [TTL_W-1:0]  out_ttl;
    } t_route_ans;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpr_req_if req_ch ();
    lpr_rsp_if rsp_ch ();

    ipv4_longest_prefix_router #(
        .ROUTES (N_ROUTES),
        .PORTS  (N_PORTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and the answers that the router still owes us.
    t_route_req req_backlog[$];
    t_route_ans due_answers[$];
    int         req_total  = 0;
    int         reqs_taken = 0;
    int         err_count  = 0;

    // Our own copy of the routing table, updated as each request is accepted.
    logic              rt_valid  [N_ROUTES];
    logic [ADDR_W-1:0] rt_prefix [N_ROUTES];
    logic [LEN_W-1:0]  rt_len    [N_ROUTES];
    logic [ADDR_W-1:0] rt_hop    [N_ROUTES];
    logic              rt_gw     [N_ROUTES];
    logic [PORT_W-1:0] rt_port   [N_ROUTES];
    int                rt_fill = 0;

    // Handshake bookkeeping shared between the sampling edge and the driving edge.
    bit req_fired = 1'b0;
    bit rsp_fired = 1'b0;
    int req_gap   = 0;
    int rsp_stall = 0;
    bit req_calm  = 1'b0;
    bit rsp_calm  = 1'b0;

    // Stimulus helpers: a handful of base addresses so that routes nest and lookups hit.
    logic [ADDR_W-1:0] bases [8];
    logic [ADDR_W-1:0] known_addr[$];
    logic [LEN_W-1:0]  known_len[$];

    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Leading-ones mask of the given length; 32 and above give all ones.
    function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        if (len == 0)
            return '0;
        if (len >= 32)
            return '1;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    // Works out the answer to one accepted request and applies any table update.
    function automatic t_route_ans decide_route(input t_route_req r);
        t_route_ans        a;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] pfx;
        logic [PORT_W-1:0] pt;
        logic [LEN_W-1:0]  best_len;
        int                slot;
        int                best;
        bit                found;
        a        = '0;
        len      = (r.prefix_len > MAX_LEN) ? MAX_LEN : r.prefix_len;
        best_len = '0;
        best     = 0;
        found    = 1'b0;
        slot     = -1;
        if (r.func == FUNC_INSERT) begin
            pfx = r.address & lead_mask(len);
            pt  = r.port_in;
            if (int'(pt) >= N_PORTS)
                pt = PORT_W'(N_PORTS - 1);
            // An existing route with the same length and prefix is overwritten in place.
            for (int i = 0; i < N_ROUTES; i++) begin
                if (slot < 0 && rt_valid[i] && rt_len[i] == len && rt_prefix[i] == pfx)
                    slot = i;
            end
            if (slot < 0 && rt_fill < N_ROUTES) begin
                slot = rt_fill;
                rt_fill++;
            end
            if (slot >= 0) begin
                rt_valid[slot]  = 1'b1;
                rt_prefix[slot] = pfx;
                rt_len[slot]    = len;
                rt_hop[slot]    = r.has_hop ? r.hop_address : '0;
                rt_gw[slot]     = r.has_hop;
                rt_port[slot]   = pt;
                a.status        = STAT_INSERTED;
            end else begin
                a.status = STAT_FULL;
            end
        end else if (r.ttl_in < TTL_MIN_FWD) begin
            a.status = STAT_DROP_TTL;
        end else begin
            // Strictly longer wins, so the earliest slot is kept on a tie.
            for (int i = 0; i < N_ROUTES; i++) begin
                if (rt_valid[i] && (r.address & lead_mask(rt_len[i])) == rt_prefix[i] &&
                        (!found || rt_len[i] > best_len)) begin
                    found    = 1'b1;
                    best     = i;
                    best_len = rt_len[i];
                end
            end
            if (found) begin
                a.status   = STAT_FORWARDED;
                a.out_port = rt_port[best];
                a.out_hop  = rt_gw[best] ? rt_hop[best] : r.address;
                a.out_ttl  = r.ttl_in - 1'b1;
            end else begin
                a.status = STAT_NO_ROUTE;
            end
        end
        return a;
    endfunction

    task automatic queue_req(input logic f, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] hop,
                             input logic gw, input logic [PORT_W-1:0] pt,
                             input logic [TTL_W-1:0] ttl);
        t_route_req r;
        r = '{f, addr, len, hop, gw, pt, ttl};
        req_backlog = {req_backlog, r};
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5)
            return '0;
        if (k < 10)
            return LEN_W'($urandom_range(33, 63));
        if (k < 20)
            return MAX_LEN;
        return LEN_W'($urandom_range(1, 31));
    endfunction

    // Builds one random request: mostly inserts and lookups around the base addresses,
    // with replacements of earlier routes and some entirely random noise.
    task automatic make_random(output t_route_req r);
        int                kind;
        int                idx;
        logic [ADDR_W-1:0] lm;
        logic [LEN_W-1:0]  len;
        kind          = $urandom_range(0, 99);
        r.func        = FUNC_ROUTE;
        r.address     = $urandom;
        r.prefix_len  = LEN_W'($urandom_range(0, 63));
        r.hop_address = $urandom;
        r.has_hop     = 1'($urandom_range(0, 1));
        r.port_in     = PORT_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       r.ttl_in = TTL_W'($urandom_range(0, 2));
            1:       r.ttl_in = 8'hFF;
            default: r.ttl_in = TTL_W'($urandom_range(2, 255));
        endcase
        if (kind < 25) begin
            r.func = FUNC_INSERT;
            if (known_addr.size() > 0 && $urandom_range(0, 9) < 4) begin
                // Replace an earlier route, with fresh junk beyond its length.
                idx          = $urandom_range(0, known_addr.size() - 1);
                len          = known_len[idx];
                lm           = lead_mask(len);
                r.prefix_len = len;
                r.address    = (known_addr[idx] & lm) | ($urandom & ~lm);
            end else begin
                len          = pick_len();
                lm           = lead_mask(len);
                r.prefix_len = len;
                if ($urandom_range(0, 9) != 0)
                    r.address = (bases[$urandom_range(0, 7)] & lm) | ($urandom & ~lm);
                // A sibling prefix differs only in its last significant bit.
                if (len >= 1 && len <= 32 && $urandom_range(0, 2) == 0)
                    r.address = r.address ^ (32'h1 << (32 - len));
                known_addr = {known_addr, r.address};
                known_len  = {known_len, len};
            end
        end else if (kind < 30) begin
            r.func = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 99) >= 15) begin
            r.address = bases[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 32));
        end
    endtask

    // Request driver: offers the next pending request after a random gap.
    always @(negedge i_clk) begin : req_driver
        logic       nv;
        t_route_req cur;
        nv = req_ch.valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (req_fired) begin
                req_fired = 1'b0;
                nv        = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    req_calm = !req_calm;
                req_gap = req_calm ? 0 : $urandom_range(0, 11);
            end
            if (!nv) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (req_backlog.size() > 0) begin
                    cur                = req_backlog.pop_front();
                    req_ch.func        <= cur.func;
                    req_ch.address     <= cur.address;
                    req_ch.prefix_len  <= cur.prefix_len;
                    req_ch.hop_address <= cur.hop_address;
                    req_ch.has_hop     <= cur.has_hop;
                    req_ch.port_in     <= cur.port_in;
                    req_ch.ttl_in      <= cur.ttl_in;
                    nv                 = 1'b1;
                end
            end
        end
        req_ch.valid <= nv;
    end

    // Result receiver: after each result it holds ready low for a random number of
    // cycles in which a result is on offer.
    always @(negedge i_clk) begin : rsp_receiver
        if (rsp_fired) begin
            rsp_fired = 1'b0;
            if ($urandom_range(0, 29) == 0)
                rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 11);
        end else if (rsp_stall > 0 && rsp_ch.valid) begin
            rsp_stall--;
        end
        rsp_ch.ready <= (rsp_stall == 0);
    end

    // Monitor: checks each result against the oldest answer owed, then records any
    // request taken on the same edge. One block keeps the queue order unambiguous.
    always @(posedge i_clk) begin : monitor
        t_route_ans want;
        t_route_req got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_fired = 1'b1;
            if (due_answers.size() == 0) begin
                flag_error($sformatf("result with no request outstanding, status %0d",
                                     rsp_ch.status));
            end else begin
                want = due_answers.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
                if (rsp_ch.out_port !== want.out_port)
                    flag_error($sformatf("out_port %0d, expected %0d",
                                         rsp_ch.out_port, want.out_port));
                if (rsp_ch.out_hop !== want.out_hop)
                    flag_error($sformatf("out_hop %08h, expected %08h",
                                         rsp_ch.out_hop, want.out_hop));
                if (rsp_ch.out_ttl !== want.out_ttl)
                    flag_error($sformatf("out_ttl %0d, expected %0d",
                                         rsp_ch.out_ttl, want.out_ttl));
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            req_fired = 1'b1;
            got = '{req_ch.func, req_ch.address, req_ch.prefix_len, req_ch.hop_address,
                    req_ch.has_hop, req_ch.port_in, req_ch.ttl_in};
            due_answers = {due_answers, decide_route(got)};
            reqs_taken++;
        end
    end

    initial begin : stimulus
        t_route_req r;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_INSERT;
        req_ch.address     = '0;
        req_ch.prefix_len  = '0;
        req_ch.hop_address = '0;
        req_ch.has_hop     = 1'b0;
        req_ch.port_in     = '0;
        req_ch.ttl_in      = '0;
        rsp_ch.ready       = 1'b0;
        for (int i = 0; i < N_ROUTES; i++)
            rt_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            bases[i] = $urandom;

        // Directed part. An empty table routes nothing, and low TTLs are dropped.
        queue_req(FUNC_ROUTE,  32'hFFFF_FFFF, 6'd0,  32'h0,         1'b0, 4'd0,  8'd255);
        queue_req(FUNC_ROUTE,  32'h0A00_0001, 6'd8,  32'h0,         1'b0, 4'd0,  8'd0);
        queue_req(FUNC_ROUTE,  32'h0A00_0001, 6'd8,  32'h0,         1'b0, 4'd0,  8'd1);
        // A direct route with junk beyond its length and a hop that must be ignored.
        queue_req(FUNC_INSERT, 32'h0A12_3456, 6'd8,  32'hDEAD_BEEF, 1'b0, 4'd5,  8'd0);
        queue_req(FUNC_ROUTE,  32'h0A00_0001, 6'd0,  32'h0,         1'b0, 4'd0,  8'd2);
        // The same prefix and length again replaces it with a gateway route.
        queue_req(FUNC_INSERT, 32'h0AFF_FFFF, 6'd8,  32'hFFFF_FFFF, 1'b1, 4'd15, 8'd0);
        queue_req(FUNC_ROUTE,  32'h0ABC_DEF0, 6'd0,  32'h0,         1'b0, 4'd0,  8'd255);
        // A default route matches every destination.
        queue_req(FUNC_INSERT, 32'h0000_0000, 6'd0,  32'h0102_0304, 1'b1, 4'd0,  8'd0);
        queue_req(FUNC_ROUTE,  32'hFFFF_FFFF, 6'd0,  32'h0,         1'b0, 4'd0,  8'd2);
        // A host route beats the default.
        queue_req(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0,         1'b0, 4'd9,  8'd0);
        queue_req(FUNC_ROUTE,  32'hFFFF_FFFF, 6'd0,  32'h0,         1'b0, 4'd0,  8'd255);
        queue_req(FUNC_ROUTE,  32'hFFFF_FFFE, 6'd0,  32'h0,         1'b0, 4'd0,  8'd100);
        // A length above 32 is taken as 32.
        queue_req(FUNC_INSERT, 32'hC0A8_0101, 6'd63, 32'h0A00_0001, 1'b1, 4'd7,  8'd0);
        queue_req(FUNC_ROUTE,  32'hC0A8_0101, 6'd0,  32'h0,         1'b0, 4'd0,  8'd64);
        queue_req(FUNC_INSERT, 32'hC0A8_01AA, 6'd24, 32'hFFFF_0000, 1'b0, 4'd2,  8'd0);
        queue_req(FUNC_ROUTE,  32'hC0A8_01FF, 6'd0,  32'h0,         1'b0, 4'd0,  8'd9);
        queue_req(FUNC_ROUTE,  32'hC0A8_0101, 6'd0,  32'h0,         1'b0, 4'd0,  8'd9);
        // An explicit /32 hits the entry that the over-long insert created.
        queue_req(FUNC_INSERT, 32'hC0A8_0101, 6'd32, 32'h0,         1'b0, 4'd1,  8'd0);
        queue_req(FUNC_ROUTE,  32'hC0A8_0101, 6'd0,  32'h0,         1'b0, 4'd0,  8'h80);
        queue_req(FUNC_ROUTE,  32'h0000_0000, 6'd0,  32'h0,         1'b0, 4'd0,  8'd1);
        queue_req(FUNC_INSERT, 32'h7FFF_FFFF, 6'd1,  32'h5555_AAAA, 1'b1, 4'd4,  8'd0);
        queue_req(FUNC_ROUTE,  32'h7FFF_FFFF, 6'd0,  32'h0,         1'b0, 4'd0,  8'd3);
        queue_req(FUNC_ROUTE,  32'h8000_0000, 6'd0,  32'h0,         1'b0, 4'd0,  8'd3);

        // Random part; the table fills part of the way through, so later new routes
        // are refused while replacements still succeed.
        repeat (N_RANDOM) begin
            make_random(r);
            req_backlog = {req_backlog, r};
        end
        req_total = req_backlog.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < req_total || due_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run of every request.
    initial begin : watchdog
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
